/* hdl/hnvs_pkg.sv */
// ----------------------------------------------------------------------------
// hnvs_pkg: shared constants and types for the nearest-vertex search
// CORDIC angle table, fixed-point constants and controller/datapath commands
// ----------------------------------------------------------------------------
`default_nettype none
package hnvs_pkg;

  localparam int METRIC_BITS_DEF = 32;
  localparam int CORDIC_STEPS    = 24;
  localparam int STEP_BITS       = 5;
  localparam int LAT_W           = 31;
  localparam int LON_W           = 32;
  localparam int IDENT_W         = 40;
  localparam int CFG_ADDR_W      = 1;
  localparam int CFG_DATA_W      = 32;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_QUERY_LAT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_QUERY_LON = 1'd1;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
  // 3.6e9 units per full turn, 3515625 = 3.6e9 / 2^10
  localparam logic [33:0] DEG_TURN = 34'd3600000000;
  localparam logic [21:0] TURN_DIV = 22'd3515625;
  // floor(2^53 / 3515625); the quotient estimate is at most two low
  localparam logic [31:0] TURN_RECIP = 32'((64'd1 << 53) / 64'(TURN_DIV));
  // rounding offset times the reciprocal
  localparam logic [63:0] TURN_BIAS  = 64'(TURN_RECIP) * 64'(TURN_DIV >> 1);

  // angle selection for one sin/cos pass
  localparam logic [1:0] ANG_DLAT  = 2'd0;
  localparam logic [1:0] ANG_DLON  = 2'd1;
  localparam logic [1:0] ANG_LAT   = 2'd2;
  localparam logic [1:0] ANG_QLAT  = 2'd3;

  // datapath commands
  typedef struct packed {
    logic       load;      // capture vertex fields
    logic       turn;      // compute turn code for selected angle
    logic [1:0] angle;     // which angle
    logic       conv_step; // one step of the angle conversion
    logic       cord_init; // start cordic from turn code
    logic       cord_step; // one cordic iteration
    logic       store;     // store the selected sin/cos result
    logic [2:0] mul_op;    // multiply phase
    logic       compare;   // compare metric and update best
    logic       clear;     // reset best state
  } hnvs_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic cord_done;
  } hnvs_sts_t;

  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_CC   = 3'd1;
  localparam logic [2:0] MUL_SS   = 3'd2;
  localparam logic [2:0] MUL_T1   = 3'd3;
  localparam logic [2:0] MUL_T2   = 3'd4;
  localparam logic [2:0] MUL_SUM  = 3'd5;

  function automatic logic [31:0] atan_turn(input logic [STEP_BITS-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/hnvs_datapath.sv */
// ----------------------------------------------------------------------------
// hnvs_datapath: angle conversion, shared CORDIC, products and best tracking
// Runs one step per cycle as told by the controller
// ----------------------------------------------------------------------------
`default_nettype none
module hnvs_datapath #(
  parameter int METRIC_BITS = hnvs_pkg::METRIC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire hnvs_pkg::hnvs_cmd_t                 cmd,
  output hnvs_pkg::hnvs_sts_t                      sts,
  input  wire logic signed [hnvs_pkg::LAT_W-1:0]   query_lat,
  input  wire logic signed [hnvs_pkg::LON_W-1:0]   query_lon,
  input  wire logic signed [hnvs_pkg::LAT_W-1:0]   point_lat,
  input  wire logic signed [hnvs_pkg::LON_W-1:0]   point_lon,
  input  wire logic [hnvs_pkg::IDENT_W-1:0]        vertex_ident,
  output logic [hnvs_pkg::IDENT_W-1:0]             best_ident,
  output logic                                     any_found
);

  localparam int SHR = 60 - METRIC_BITS;

  // captured vertex
  logic signed [hnvs_pkg::LAT_W-1:0] lat_r;
  logic signed [hnvs_pkg::LON_W-1:0] lon_r;
  logic [hnvs_pkg::IDENT_W-1:0]      id_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat_r <= point_lat;
      lon_r <= point_lon;
      id_r  <= vertex_ident;
    end
  end

  // angle difference, reduced modulo one turn (value within (-2 turns, 2 turns))
  logic signed [33:0] diff;
  logic signed [34:0] red0;
  logic [33:0]        ured;
  logic               half;
  always_comb begin
    unique case (cmd.angle)
      hnvs_pkg::ANG_DLAT: diff = 34'(lat_r) - 34'(query_lat);
      hnvs_pkg::ANG_DLON: diff = 34'(lon_r) - 34'(query_lon);
      hnvs_pkg::ANG_LAT:  diff = 34'(lat_r);
      default:            diff = 34'(query_lat);
    endcase
    half = (cmd.angle == hnvs_pkg::ANG_DLAT) || (cmd.angle == hnvs_pkg::ANG_DLON);
    red0 = 35'(diff);
    if (red0 < 0) red0 = red0 + 35'(hnvs_pkg::DEG_TURN);
    if (red0 < 0) red0 = red0 + 35'(hnvs_pkg::DEG_TURN);
    if (red0 >= 35'(hnvs_pkg::DEG_TURN)) red0 = red0 - 35'(hnvs_pkg::DEG_TURN);
    ured = red0[33:0];
  end

  // turn code (u*2^k + D/2) / D by reciprocal multiply, then remainder fix-up
  // steps: multiply, quotient estimate, remainder, two corrections
  logic [31:0] u_r;
  logic        half_r;
  logic [63:0] prod_u_r;
  logic [55:0] num_r;
  logic [33:0] quo_r;
  logic [23:0] rem_r;
  logic [2:0]  dcnt_r;
  logic [86:0] est;
  logic [55:0] qd;
  assign est = (half_r ? (87'(prod_u_r) << 21) : (87'(prod_u_r) << 22))
               + 87'(hnvs_pkg::TURN_BIAS);
  assign qd  = 56'(quo_r) * 56'(hnvs_pkg::TURN_DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.turn) begin
      u_r    <= ured[31:0];
      half_r <= half;
      dcnt_r <= 3'd5;
    end else if (cmd.conv_step && dcnt_r != 0) begin
      unique case (dcnt_r)
        3'd5: begin
          prod_u_r <= 64'(u_r) * 64'(hnvs_pkg::TURN_RECIP);
          num_r    <= (half_r ? (56'(u_r) << 21) : (56'(u_r) << 22))
                      + 56'(hnvs_pkg::TURN_DIV >> 1);
        end
        3'd4: quo_r <= est[86:53];
        3'd3: rem_r <= 24'(num_r - qd);
        default: begin
          if (rem_r >= 24'(hnvs_pkg::TURN_DIV)) begin
            quo_r <= quo_r + 34'd1;
            rem_r <= rem_r - 24'(hnvs_pkg::TURN_DIV);
          end
        end
      endcase
      dcnt_r <= dcnt_r - 3'd1;
    end
  end
  assign sts.conv_done = (dcnt_r == 0);

  // cordic
  logic signed [33:0] x_r, y_r, z_r;
  logic [1:0]         quad_r;
  logic [hnvs_pkg::STEP_BITS-1:0] step_r;
  logic               cbusy_r;
  logic signed [33:0] dx, dy, at;
  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;
  assign at = 34'(hnvs_pkg::atan_turn(step_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cbusy_r <= 1'b0;
      step_r  <= '0;
    end else if (cmd.cord_init) begin
      x_r     <= hnvs_pkg::CORDIC_GAIN;
      y_r     <= '0;
      z_r     <= 34'(quo_r[29:0]);
      quad_r  <= quo_r[31:30];
      step_r  <= '0;
      cbusy_r <= 1'b1;
    end else if (cmd.cord_step && cbusy_r) begin
      if (!z_r[33]) begin
        x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + at;
      end
      if (step_r == 5'(hnvs_pkg::CORDIC_STEPS - 1)) cbusy_r <= 1'b0;
      else step_r <= step_r + 5'd1;
    end
  end
  assign sts.cord_done = !cbusy_r;

  // saturation and quadrant mapping
  logic signed [31:0] xs, ys, s_v, c_v;
  always_comb begin
    xs = (x_r > hnvs_pkg::Q30_ONE) ? 32'sd1073741824 :
         (x_r < -hnvs_pkg::Q30_ONE) ? -32'sd1073741824 : 32'(x_r);
    ys = (y_r > hnvs_pkg::Q30_ONE) ? 32'sd1073741824 :
         (y_r < -hnvs_pkg::Q30_ONE) ? -32'sd1073741824 : 32'(y_r);
    unique case (quad_r)
      2'd0: begin s_v = ys;  c_v = xs;  end
      2'd1: begin s_v = xs;  c_v = -ys; end
      2'd2: begin s_v = -ys; c_v = -xs; end
      default: begin s_v = -xs; c_v = ys; end
    endcase
  end

  logic signed [31:0] s1_r, s2_r, c1_r, c0_r;
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      unique case (cmd.angle)
        hnvs_pkg::ANG_DLAT: s1_r <= s_v;
        hnvs_pkg::ANG_DLON: s2_r <= s_v;
        hnvs_pkg::ANG_LAT:  c1_r <= c_v;
        default:            c0_r <= c_v;
      endcase
    end
  end

  // products, one multiply per cycle
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [33:0] cc_r, ss_r;
  logic signed [63:0] t1_r, t2_r;
  logic [METRIC_BITS-1:0] metric_r;
  logic signed [64:0] asum;
  logic [60:0]        aclamp;
  logic [60-SHR:0]    msh;
  always_comb begin
    unique case (cmd.mul_op)
      hnvs_pkg::MUL_CC: begin ma = c1_r; mb = c0_r; end
      hnvs_pkg::MUL_SS: begin ma = s2_r; mb = s2_r; end
      hnvs_pkg::MUL_T1: begin ma = s1_r; mb = s1_r; end
      default:          begin ma = 32'(cc_r); mb = 32'(ss_r); end
    endcase
    prod = 64'(ma) * 64'(mb);
    asum = 65'(t1_r) + 65'(t2_r);
    if (asum < 0) aclamp = '0;
    else if (asum > (65'sd1 <<< 60)) aclamp = 61'd1 << 60;
    else aclamp = asum[60:0];
    msh = aclamp[60:SHR];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.mul_op)
      hnvs_pkg::MUL_CC: cc_r <= 34'(prod >>> 30);
      hnvs_pkg::MUL_SS: ss_r <= 34'(prod >>> 30);
      hnvs_pkg::MUL_T1: t1_r <= prod;
      hnvs_pkg::MUL_T2: t2_r <= prod;
      hnvs_pkg::MUL_SUM:
        metric_r <= msh[60-SHR] ? '1 : msh[METRIC_BITS-1:0];
      default: ;
    endcase
  end

  // best tracking
  logic [METRIC_BITS-1:0] best_metric_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      best_metric_r <= '1;
      best_ident    <= '0;
      any_found     <= 1'b0;
    end else if (cmd.compare && (!any_found || metric_r < best_metric_r)) begin
      best_metric_r <= metric_r;
      best_ident    <= id_r;
      any_found     <= 1'b1;
    end
  end

endmodule
`default_nettype wire

/* hdl/hnvs_ctrl.sv */
// ----------------------------------------------------------------------------
// hnvs_ctrl: sequencer for one vertex
// Walks four angle passes (convert, cordic, store), then the products
// ----------------------------------------------------------------------------
`default_nettype none
module hnvs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_main_part,
  input  wire logic                 last_vertex,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output hnvs_pkg::hnvs_cmd_t       cmd,
  input  wire hnvs_pkg::hnvs_sts_t  sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TURN  = 4'd1;
  localparam logic [3:0] S_CONV  = 4'd2;
  localparam logic [3:0] S_CINIT = 4'd3;
  localparam logic [3:0] S_CORD  = 4'd4;
  localparam logic [3:0] S_STORE = 4'd5;
  localparam logic [3:0] S_M1    = 4'd6;
  localparam logic [3:0] S_M2    = 4'd7;
  localparam logic [3:0] S_M3    = 4'd8;
  localparam logic [3:0] S_M4    = 4'd9;
  localparam logic [3:0] S_SUM   = 4'd10;
  localparam logic [3:0] S_CMP   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [1:0] ang_r, ang_nxt;
  logic       last_r, last_nxt;
  logic       accept;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ang_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ang_r   <= ang_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ang_nxt   = ang_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.angle = ang_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = accept;
        if (accept) begin
          last_nxt = last_vertex;
          ang_nxt  = hnvs_pkg::ANG_DLAT;
          if (in_main_part) state_nxt = S_TURN;
          else if (last_vertex) state_nxt = S_OUT;
        end
      end
      S_TURN: begin cmd.turn = 1'b1; state_nxt = S_CONV; end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_done) state_nxt = S_CINIT;
      end
      S_CINIT: begin cmd.cord_init = 1'b1; state_nxt = S_CORD; end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (sts.cord_done) state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        ang_nxt   = ang_r + 2'd1;
        state_nxt = (ang_r == hnvs_pkg::ANG_QLAT) ? S_M1 : S_TURN;
      end
      S_M1: begin cmd.mul_op = hnvs_pkg::MUL_CC; state_nxt = S_M2; end
      S_M2: begin cmd.mul_op = hnvs_pkg::MUL_SS; state_nxt = S_M3; end
      S_M3: begin cmd.mul_op = hnvs_pkg::MUL_T1; state_nxt = S_M4; end
      S_M4: begin cmd.mul_op = hnvs_pkg::MUL_T2; state_nxt = S_SUM; end
      S_SUM: begin cmd.mul_op = hnvs_pkg::MUL_SUM; state_nxt = S_CMP; end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = last_r ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/haversine_nearest_vertex_search.sv */
// ----------------------------------------------------------------------------
// haversine_nearest_vertex_search: nearest vertex to a query point
// Keeps the eligible vertex with the smallest haversine term
//
//   channel  | direction | handshake        | payload
//   in_      | input     | in_valid/stall   | lat, lon, ident, main, last
//   out_     | output    | out_valid/stall  | nearest_ident, found
//   cfg_     | input     | cfg_valid/ready  | index, data
//
// an eligible vertex passes the accept, four angle passes (setup, turn
// conversion, cordic load, cordic iterations, store) and then the products
// and the compare before the next acceptance
// an ineligible vertex leaves the sequencer idle; a last one adds the result
// synchronous active-low reset clears the best state and the sequencer
// in_stall is high while a vertex is in work or a result waits
// ----------------------------------------------------------------------------
`default_nettype none
module haversine_nearest_vertex_search #(
  parameter int METRIC_BITS = hnvs_pkg::METRIC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [hnvs_pkg::LAT_W-1:0]     in_point_lat,
  input  wire logic signed [hnvs_pkg::LON_W-1:0]     in_point_lon,
  input  wire logic [hnvs_pkg::IDENT_W-1:0]          in_vertex_ident,
  input  wire logic                                  in_in_main_part,
  input  wire logic                                  in_last_vertex,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [hnvs_pkg::IDENT_W-1:0]               out_nearest_ident,
  output logic                                       out_found,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [hnvs_pkg::CFG_ADDR_W-1:0]       cfg_index,
  input  wire logic [hnvs_pkg::CFG_DATA_W-1:0]       cfg_data
);

  hnvs_pkg::hnvs_cmd_t cmd;
  hnvs_pkg::hnvs_sts_t sts;
  logic signed [hnvs_pkg::LAT_W-1:0] query_lat_r;
  logic signed [hnvs_pkg::LON_W-1:0] query_lon_r;
  logic [hnvs_pkg::IDENT_W-1:0] best_ident;
  logic any_found;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_lat_r <= '0;
      query_lon_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == hnvs_pkg::REG_QUERY_LAT) query_lat_r <= cfg_data[hnvs_pkg::LAT_W-1:0];
      if (cfg_index == hnvs_pkg::REG_QUERY_LON) query_lon_r <= cfg_data;
    end
  end

  hnvs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_main_part(in_in_main_part), .last_vertex(in_last_vertex),
    .out_valid, .out_stall, .cmd, .sts
  );

  hnvs_datapath #(.METRIC_BITS(METRIC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .query_lat(query_lat_r), .query_lon(query_lon_r),
    .point_lat(in_point_lat), .point_lon(in_point_lon),
    .vertex_ident(in_vertex_ident), .best_ident, .any_found
  );

  assign out_nearest_ident = any_found ? best_ident : '0;
  assign out_found         = any_found;

`ifndef ASSERT_OFF
  // no result is shown while the sequencer takes vertices
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result while accepting");
  // a delivered result clears the found flag
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_found) else $error("state not cleared");
  // the ident is zero whenever found is low
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_found |-> (out_nearest_ident == '0)) else $error("ident without found");
`endif

endmodule
`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for haversine_nearest_vertex_search
// Streams vertex scans under several query points, predicts the nearest
// eligible vertex with a bit-exact fixed-point haversine model and checks
// every result, with random idling on both sides and long receiver holds
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

  localparam int  HALF_PERIOD  = 6;
  localparam int  WATCH_LIMIT  = 20000;
  localparam int  SETTLE_CYC   = 400;
  localparam int  HOLD_CYC     = 3000;
  localparam int  NUM_RANDOM   = 840;
  localparam longint TURN_UNITS = 64'sd3600000000;
  localparam longint TURN_STEP  = 64'sd3515625;
  localparam longint UNIT_Q30   = 64'sd1073741824;
  localparam longint GAIN_Q30   = 64'sd652032874;
  localparam longint ARC_TURN [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    longint lat;
    longint lon;
    logic [hnvs_pkg::IDENT_W-1:0] ident;
    logic main_part;
    logic last;
    logic typed;
    logic [hnvs_pkg::IDENT_W-1:0] want_ident;
    logic want_found;
  } vertex_row_t;

  typedef struct {
    logic [hnvs_pkg::IDENT_W-1:0] ident;
    logic found;
  } nearest_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [hnvs_pkg::LAT_W-1:0] in_point_lat;
  logic signed [hnvs_pkg::LON_W-1:0] in_point_lon;
  logic [hnvs_pkg::IDENT_W-1:0] in_vertex_ident;
  logic in_in_main_part;
  logic in_last_vertex;
  logic out_valid;
  logic out_stall;
  logic [hnvs_pkg::IDENT_W-1:0] out_nearest_ident;
  logic out_found;
  logic cfg_valid;
  logic cfg_ready;
  logic [hnvs_pkg::CFG_ADDR_W-1:0] cfg_index;
  logic [hnvs_pkg::CFG_DATA_W-1:0] cfg_data;

  // query point and running best, as the block should hold them
  longint query_lat_q;
  longint query_lon_q;
  longint best_metric_q;
  logic [hnvs_pkg::IDENT_W-1:0] best_ident_q;
  logic best_valid_q;

  nearest_t nearest_fifo[$];
  int errors;
  int vertices_sent;
  int results_seen;
  int quiet_cycles;
  int hold_cnt;
  bit no_idle;

  haversine_nearest_vertex_search DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_lat(in_point_lat), .in_point_lon(in_point_lon),
    .in_vertex_ident(in_vertex_ident), .in_in_main_part(in_in_main_part),
    .in_last_vertex(in_last_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_nearest_ident(out_nearest_ident), .out_found(out_found),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // angle difference to turn code, half or full angle
  function automatic longint angle_turn(input longint d, input int shift);
    longint u;
    u = d % TURN_UNITS;
    if (u < 0) u += TURN_UNITS;
    return (u * (64'sd1 << shift) + TURN_STEP / 2) / TURN_STEP;
  endfunction

  function automatic longint clip_unit(input longint v);
    if (v > UNIT_Q30) return UNIT_Q30;
    if (v < -UNIT_Q30) return -UNIT_Q30;
    return v;
  endfunction

  // quadrant fold plus rotation cordic
  task automatic cordic_sin_cos(input longint turn, output longint s, output longint c);
    longint x, y, z, dx, dy;
    logic [31:0] t;
    t = turn[31:0];
    z = longint'(t[29:0]);
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < hnvs_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARC_TURN[i];
      end else begin
        x += dx; y -= dy; z += ARC_TURN[i];
      end
    end
    x = clip_unit(x);
    y = clip_unit(y);
    case (t[31:30])
      2'd0: begin s = y;  c = x;  end
      2'd1: begin s = x;  c = -y; end
      2'd2: begin s = -y; c = -x; end
      default: begin s = -x; c = y; end
    endcase
  endtask

  // haversine term truncated to the metric width
  task automatic haversine_term(input longint lat, input longint lon, output longint m);
    longint s1, s2, c1, c0, unused, cc, ss, a;
    cordic_sin_cos(angle_turn(lat - query_lat_q, 21), s1, unused);
    cordic_sin_cos(angle_turn(lon - query_lon_q, 21), s2, unused);
    cordic_sin_cos(angle_turn(lat, 22), unused, c1);
    cordic_sin_cos(angle_turn(query_lat_q, 22), unused, c0);
    cc = (c1 * c0) >>> 30;
    ss = (s2 * s2) >>> 30;
    a = s1 * s1 + cc * ss;
    if (a < 0) a = 0;
    if (a > UNIT_Q30 * UNIT_Q30) a = UNIT_Q30 * UNIT_Q30;
    m = a >>> (60 - hnvs_pkg::METRIC_BITS_DEF);
    if (m > 64'sd4294967295) m = 64'sd4294967295;
  endtask

  task automatic clear_best();
    best_metric_q = 64'sd4294967295;
    best_ident_q = '0;
    best_valid_q = 1'b0;
  endtask

  // update best for one accepted vertex, returns 1 when a result is due
  task automatic track_nearest(input vertex_row_t v, output bit due, output nearest_t r);
    longint m;
    due = 1'b0;
    r.ident = '0;
    r.found = 1'b0;
    if (v.main_part) begin
      haversine_term(v.lat, v.lon, m);
      if (!best_valid_q || m < best_metric_q) begin
        best_metric_q = m;
        best_ident_q = v.ident;
        best_valid_q = 1'b1;
      end
    end
    if (v.last) begin
      due = 1'b1;
      r.ident = best_valid_q ? best_ident_q : '0;
      r.found = best_valid_q;
      clear_best();
    end
  endtask

  // idle gap on the request side
  task automatic maybe_idle();
    int gap;
    if (!no_idle && $urandom_range(0, 99) < 19) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drive one vertex request and wait for it to be taken
  task automatic send_vertex(input vertex_row_t v);
    bit due;
    nearest_t r;
    maybe_idle();
    @(negedge clk);
    in_valid = 1'b1;
    in_point_lat = v.lat[hnvs_pkg::LAT_W-1:0];
    in_point_lon = v.lon[hnvs_pkg::LON_W-1:0];
    in_vertex_ident = v.ident;
    in_in_main_part = v.main_part;
    in_last_vertex = v.last;
    // predict from the coordinates as they wrap on the ports
    v.lat = longint'(in_point_lat);
    v.lon = longint'(in_point_lon);
    do @(posedge clk); while (in_stall);
    track_nearest(v, due, r);
    if (due) begin
      if (v.typed) begin
        r.ident = v.want_ident;
        r.found = v.want_found;
      end
      nearest_fifo.insert(nearest_fifo.size(), r);
    end
    vertices_sent++;
  endtask

  // wait for all results, let the datapath settle, then write a register
  task automatic write_query(input logic [hnvs_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [31:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    while (nearest_fifo.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == hnvs_pkg::REG_QUERY_LAT)
      query_lat_q = longint'($signed(val[hnvs_pkg::LAT_W-1:0]));
    else query_lon_q = longint'($signed(val));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic vertex_row_t random_vertex();
    vertex_row_t v;
    logic [63:0] id;
    id = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) begin
      v.lat = longint'($signed(31'($urandom)));
      v.lon = longint'($signed(32'($urandom)));
    end else begin
      v.lat = longint'($urandom_range(0, 1800000000)) - 900000000;
      v.lon = longint'($urandom_range(0, 3600000000)) - 1800000000;
    end
    v.ident = id[hnvs_pkg::IDENT_W-1:0];
    v.main_part = $urandom_range(0, 99) < 75;
    v.last = 1'b0;
    v.typed = 1'b0;
    v.want_ident = '0;
    v.want_found = 1'b0;
    return v;
  endfunction

  // result receiver with random and forced holds
  initial begin
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        out_stall = 1'b1;
        hold_cnt--;
      end else begin
        out_stall = !no_idle && ($urandom_range(0, 99) < 19);
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    nearest_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCH_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (nearest_fifo.size() == 0) begin
          $display("%0t: unexpected result ident=%h found=%b", $time,
                   out_nearest_ident, out_found);
          errors++;
        end else begin
          e = nearest_fifo.pop_front();
          if (out_nearest_ident !== e.ident) begin
            $display("%0t: nearest_ident expected %h actual %h", $time, e.ident,
                     out_nearest_ident);
            errors++;
          end
          if (out_found !== e.found) begin
            $display("%0t: found expected %b actual %b", $time, e.found, out_found);
            errors++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    vertex_row_t directed[$];
    vertex_row_t v;
    int scan_left;
    int per_phase;
    logic [31:0] lat_cfg [0:3];
    logic [31:0] lon_cfg [0:3];

    errors = 0;
    vertices_sent = 0;
    results_seen = 0;
    quiet_cycles = 0;
    hold_cnt = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_point_lat = '0;
    in_point_lon = '0;
    in_vertex_ident = '0;
    in_in_main_part = 1'b0;
    in_last_vertex = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = hnvs_pkg::REG_QUERY_LAT;
    cfg_data = '0;
    query_lat_q = 0;
    query_lon_q = 0;
    clear_best();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // lat, lon, ident, main, last, typed, expected ident, expected found
    // no eligible vertex at all
    directed.insert(directed.size(), '{0, 0, 40'd1, 1'b0, 1'b1, 1'b1, 40'd0, 1'b0});
    // lone eligible vertex at the extremes is taken
    directed.insert(directed.size(), '{900000000, 1800000000, {hnvs_pkg::IDENT_W{1'b1}},
                    1'b1, 1'b1, 1'b1, {hnvs_pkg::IDENT_W{1'b1}}, 1'b1});
    directed.insert(directed.size(),
                    '{-900000000, -1800000000, 40'd5, 1'b1, 1'b0, 1'b1, 40'd0, 1'b0});
    directed.insert(directed.size(),
                    '{-900000000, -1800000000, 40'd9, 1'b1, 1'b1, 1'b1, 40'd5, 1'b1});
    // equal metrics keep the earlier vertex
    directed.insert(directed.size(), '{0, 0, 40'd6, 1'b1, 1'b0, 1'b0, 40'd0, 1'b0});
    directed.insert(directed.size(), '{0, 0, 40'd7, 1'b1, 1'b0, 1'b0, 40'd0, 1'b0});
    // ineligible last vertex still ends the scan
    directed.insert(directed.size(),
                    '{1073741823, 2147483647, 40'd8, 1'b0, 1'b1, 1'b0, 40'd0, 1'b0});
    // coordinates past the legal range wrap
    directed.insert(directed.size(),
                    '{-1073741824, -2147483648, 40'd10, 1'b1, 1'b0, 1'b0, 40'd0, 1'b0});
    directed.insert(directed.size(),
                    '{1073741823, 2147483647, 40'd11, 1'b1, 1'b0, 1'b0, 40'd0, 1'b0});
    directed.insert(directed.size(),
                    '{950000000, 10, 40'd12, 1'b1, 1'b1, 1'b0, 40'd0, 1'b0});
    directed.insert(directed.size(), '{0, 0, 40'd13, 1'b0, 1'b0, 1'b0, 40'd0, 1'b0});
    directed.insert(directed.size(), '{0, 0, 40'd14, 1'b0, 1'b1, 1'b1, 40'd0, 1'b0});
    directed.insert(directed.size(), '{0, 0, 40'd0, 1'b1, 1'b1, 1'b1, 40'd0, 1'b1});
    foreach (directed[i]) send_vertex(directed[i]);

    // query points: extremes, wrapped raw values, random
    lat_cfg[0] = 32'd900000000;           lon_cfg[0] = 32'd1800000000;
    lat_cfg[1] = -32'sd900000000;         lon_cfg[1] = -32'sd1800000000;
    lat_cfg[2] = 32'hBFFF_FFFF;           lon_cfg[2] = 32'h8000_0000;
    lat_cfg[3] = $urandom;                lon_cfg[3] = $urandom;
    per_phase = NUM_RANDOM / 4;

    for (int p = 0; p < 4; p++) begin
      write_query(hnvs_pkg::REG_QUERY_LAT, lat_cfg[p]);
      write_query(hnvs_pkg::REG_QUERY_LON, lon_cfg[p]);
      no_idle = (p == 0);
      scan_left = 0;
      for (int n = 0; n < per_phase; n++) begin
        if (p == 1 && n == per_phase / 2) hold_cnt = HOLD_CYC;
        if (p == 2 && n == per_phase / 2) begin
          @(negedge clk);
          in_valid = 1'b0;
          while (nearest_fifo.size() != 0) @(negedge clk);
        end
        if (scan_left == 0)
          scan_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(1, 6);
        v = random_vertex();
        // near the query point, so nearest selection is exercised
        if ($urandom_range(0, 2) == 0) begin
          v.lat = query_lat_q + longint'($urandom_range(0, 2000)) - 1000;
          v.lon = query_lon_q + longint'($urandom_range(0, 2000)) - 1000;
        end
        scan_left--;
        v.last = (scan_left == 0) || (n == per_phase - 1);
        if (v.last) scan_left = 0;
        send_vertex(v);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (nearest_fifo.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    $display("run covered %0d vertices and %0d results over five query points",
             vertices_sent, results_seen);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire

/* haversine_nearest_vertex_search.f */
hdl/hnvs_pkg.sv
hdl/hnvs_datapath.sv
hdl/hnvs_ctrl.sv
hdl/haversine_nearest_vertex_search.sv
verif/testbench.sv
